// File: design/cpfg_pkg.sv
// Package for the circular pipe flow geometry unit.
// Holds the shared widths, angle constants, the CORDIC arctangent table and
// the beat structures; it depends on nothing else.
package cpfg_pkg;

  localparam int D_W    = 16;  // diameter and depth, Q8.8
  localparam int C_W    = 18;  // D - 2*yc, signed
  localparam int T_W    = 17;  // top width, Q9.8
  localparam int H_W    = 26;  // half angle, Q.24, 0..pi
  localparam int X_W    = 32;  // CORDIC vector components
  localparam int Z_W    = 28;  // CORDIC angle accumulator, signed
  localparam int Q_W    = 17;  // quotient bits of the slope divisions
  localparam int RAD_W  = 34;  // radicand 4*yc*(D-yc)
  localparam int REM_W  = 18;  // square root partial remainder
  localparam int PRE_SH = 12;  // CORDIC input prescale by 4096

  localparam logic [H_W-1:0] ANG_PI      = 26'd52707179;
  localparam logic [H_W-1:0] ANG_HALF_PI = 26'd26353589;
  localparam logic [15:0]    THETA_MAX   = 16'd51472;

  typedef struct packed {
    logic [D_W-1:0] d;
    logic [C_W-1:0] c;
    logic [T_W-1:0] t;
    logic           ge;
    logic           le;
    logic [H_W-1:0] h;
    logic           ovf_p;
    logic           ovf_w;
  } item_t;

  typedef struct packed {
    logic [15:0]    theta;
    logic [15:0]    pslope;
    logic [15:0]    wslope;
    logic           sat;
    logic [T_W-1:0] top;
    logic [17:0]    perim;
  } res_t;

  function automatic logic [Z_W-1:0] atan_q24(input logic [4:0] idx);
    logic [Z_W-1:0] a;
    unique case (idx)
      5'd0:    a = 28'd13176795;
      5'd1:    a = 28'd7778716;
      5'd2:    a = 28'd4110060;
      5'd3:    a = 28'd2086331;
      5'd4:    a = 28'd1047214;
      5'd5:    a = 28'd524117;
      5'd6:    a = 28'd262123;
      5'd7:    a = 28'd131069;
      5'd8:    a = 28'd65536;
      5'd9:    a = 28'd32768;
      5'd10:   a = 28'd16384;
      5'd11:   a = 28'd8192;
      5'd12:   a = 28'd4096;
      5'd13:   a = 28'd2048;
      5'd14:   a = 28'd1024;
      5'd15:   a = 28'd512;
      5'd16:   a = 28'd256;
      5'd17:   a = 28'd128;
      5'd18:   a = 28'd64;
      5'd19:   a = 28'd32;
      5'd20:   a = 28'd16;
      5'd21:   a = 28'd8;
      5'd22:   a = 28'd4;
      5'd23:   a = 28'd2;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: design/circular_pipe_flow_geometry_unit.sv
// Top level of the circular pipe partial-flow geometry unit.
// Depends on cpfg_pkg, cpfg_sqrt_cell, cpfg_cordic_cell and cpfg_div_cell.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+-------------------------------
//   input    | in        | in_valid_i / in_ready_o  | flow_depth_i
//   result   | out       | out_valid_o / out_ready_i| angle, area, perimeter, widths
//   config   | in        | cfg_we_i (no wait)       | cfg_wdata_i (pipe diameter)
//
// A new beat can enter in every cycle unless the chain stalls. A beat passes the front
// stage, 17 square root cells, the CORDIC cells, 17 divider cells and the other stages.
// Reset clears the valid chain and loads a diameter of 1.0; payload is not reset.
// The whole chain advances together: it stalls only while a finished result sits
// in the output register and the consumer does not take it.
//
// Flow of one beat: the front stage clamps the depth and forms 4*yc*(D-yc); the
// square root cells give the top width T; a pre-rotation and the CORDIC cells give
// the half angle h = atan2(T, D-2yc); a set-up stage clamps h and forms the two
// slope numerators, which the divider cells reduce one quotient bit per cell; the
// last stages multiply out the area and perimeter and saturate everything.
module circular_pipe_flow_geometry_unit #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS     = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] flow_depth_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] central_angle_o,
  output logic [23:0] flow_area_o,
  output logic [17:0] wetted_perimeter_o,
  output logic [16:0] top_width_o,
  output logic [15:0] perimeter_slope_o,
  output logic [15:0] width_slope_o,
  output logic        slope_saturated_o
);

  localparam int SqSteps  = cpfg_pkg::T_W;
  localparam int DivSteps = cpfg_pkg::Q_W;
  localparam int NumW     = cpfg_pkg::D_W + 2 + FRAC_BITS;
  localparam int NStages  = 1 + SqSteps + 1 + CORDIC_STAGES + 1 + DivSteps + 4;
  localparam int AreaSh   = FRAC_BITS + 26;

  // The pipe diameter register.
  logic [15:0] pipe_diameter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_diameter_q <= 16'd256;
    end else if (cfg_we_i) begin
      pipe_diameter_q <= cfg_wdata_i;
    end
  end

  // Valid bits travel beside the payload; everything moves on one enable.
  logic [NStages-1:0] vld_q;
  logic               en;

  assign en          = !vld_q[NStages-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStages-2:0], in_valid_i};
    end
  end

  // Front stage: clamp the depth, find the special cases and the radicand.
  logic signed [16:0]            y_s, d_s;
  logic [15:0]                   yc, rest;
  logic [31:0]                   prod;
  cpfg_pkg::item_t               front_d, front_q;
  logic [cpfg_pkg::RAD_W-1:0]    rad_q;

  always_comb begin
    y_s = {flow_depth_i[15], flow_depth_i};
    d_s = {1'b0, pipe_diameter_q};
    if (flow_depth_i[15]) begin
      yc = '0;
    end else if (y_s > d_s) begin
      yc = pipe_diameter_q;
    end else begin
      yc = flow_depth_i;
    end
    rest          = pipe_diameter_q - yc;
    prod          = yc * rest;
    front_d       = '0;
    front_d.d     = pipe_diameter_q;
    front_d.c     = {2'b00, pipe_diameter_q} - {1'b0, yc, 1'b0};
    front_d.ge    = (y_s >= d_s);
    front_d.le    = (y_s <= 17'sd0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      front_q <= front_d;
      rad_q   <= {prod, 2'b00};
    end
  end

  // Square root chain: one result bit per cell, most significant first.
  cpfg_pkg::item_t                sq_item [SqSteps+1];
  logic [cpfg_pkg::RAD_W-1:0]     sq_rad  [SqSteps+1];
  logic [cpfg_pkg::REM_W-1:0]     sq_rem  [SqSteps+1];
  logic [cpfg_pkg::T_W-1:0]       sq_root [SqSteps+1];

  assign sq_item[0] = front_q;
  assign sq_rad[0]  = rad_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    cpfg_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .item_i (sq_item[k]),
      .rad_i  (sq_rad[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .item_o (sq_item[k+1]),
      .rad_o  (sq_rad[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1])
    );
  end

  // CORDIC set-up: scale by 4096 and turn a vector with negative x by -90 degrees.
  cpfg_pkg::item_t                   pre_item_d, pre_item_q;
  logic signed [cpfg_pkg::X_W-1:0]   xs, ys, pre_x_d, pre_y_d, pre_x_q, pre_y_q;
  logic signed [cpfg_pkg::Z_W-1:0]   pre_z_d, pre_z_q;

  always_comb begin
    pre_item_d   = sq_item[SqSteps];
    pre_item_d.t = sq_root[SqSteps];
    xs = {{(cpfg_pkg::X_W - cpfg_pkg::C_W - cpfg_pkg::PRE_SH){pre_item_d.c[cpfg_pkg::C_W-1]}},
          pre_item_d.c, {cpfg_pkg::PRE_SH{1'b0}}};
    ys = {{(cpfg_pkg::X_W - cpfg_pkg::T_W - cpfg_pkg::PRE_SH){1'b0}},
          pre_item_d.t, {cpfg_pkg::PRE_SH{1'b0}}};
    if (pre_item_d.c[cpfg_pkg::C_W-1]) begin
      pre_x_d = ys;
      pre_y_d = -xs;
      pre_z_d = $signed({{(cpfg_pkg::Z_W - cpfg_pkg::H_W){1'b0}}, cpfg_pkg::ANG_HALF_PI});
    end else begin
      pre_x_d = xs;
      pre_y_d = ys;
      pre_z_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pre_item_q <= pre_item_d;
      pre_x_q    <= pre_x_d;
      pre_y_q    <= pre_y_d;
      pre_z_q    <= pre_z_d;
    end
  end

  // CORDIC chain in vectoring mode.
  cpfg_pkg::item_t                   cr_item [CORDIC_STAGES+1];
  logic signed [cpfg_pkg::X_W-1:0]   cr_x    [CORDIC_STAGES+1];
  logic signed [cpfg_pkg::X_W-1:0]   cr_y    [CORDIC_STAGES+1];
  logic signed [cpfg_pkg::Z_W-1:0]   cr_z    [CORDIC_STAGES+1];

  assign cr_item[0] = pre_item_q;
  assign cr_x[0]    = pre_x_q;
  assign cr_y[0]    = pre_y_q;
  assign cr_z[0]    = pre_z_q;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    cpfg_cordic_cell #(.IDX(i)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .item_i (cr_item[i]),
      .x_i    (cr_x[i]),
      .y_i    (cr_y[i]),
      .z_i    (cr_z[i]),
      .item_o (cr_item[i+1]),
      .x_o    (cr_x[i+1]),
      .y_o    (cr_y[i+1]),
      .z_o    (cr_z[i+1])
    );
  end

  // Division set-up: clamp the half angle and form the rounded numerators.
  // A quotient that would need more than 17 bits is flagged here and saturated later.
  cpfg_pkg::item_t                  ds_item_d, ds_item_q;
  logic signed [cpfg_pkg::Z_W-1:0]  zf;
  logic [cpfg_pkg::C_W-1:0]         cabs;
  logic [NumW-1:0]                  num_p_d, num_w_d, num_p_q, num_w_q;

  always_comb begin
    ds_item_d = cr_item[CORDIC_STAGES];
    zf        = cr_z[CORDIC_STAGES];
    if (ds_item_d.ge) begin
      ds_item_d.h = cpfg_pkg::ANG_PI;
    end else if (ds_item_d.le || zf < 0) begin
      ds_item_d.h = '0;
    end else if (zf > $signed({{(cpfg_pkg::Z_W - cpfg_pkg::H_W){1'b0}}, cpfg_pkg::ANG_PI})) begin
      ds_item_d.h = cpfg_pkg::ANG_PI;
    end else begin
      ds_item_d.h = zf[cpfg_pkg::H_W-1:0];
    end
    cabs = ds_item_d.c[cpfg_pkg::C_W-1] ? -ds_item_d.c : ds_item_d.c;
    num_p_d = (NumW'({ds_item_d.d, 1'b0}) << FRAC_BITS)
              + NumW'(ds_item_d.t[cpfg_pkg::T_W-1:1]);
    num_w_d = (NumW'({cabs[15:0], 1'b0}) << FRAC_BITS)
              + NumW'(ds_item_d.t[cpfg_pkg::T_W-1:1]);
    ds_item_d.ovf_p = (num_p_d >> cpfg_pkg::Q_W) >= NumW'(ds_item_d.t);
    ds_item_d.ovf_w = (num_w_d >> cpfg_pkg::Q_W) >= NumW'(ds_item_d.t);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ds_item_q <= ds_item_d;
      num_p_q   <= num_p_d;
      num_w_q   <= num_w_d;
    end
  end

  // Divider chain: quotient bit 16 first, down to bit 0.
  cpfg_pkg::item_t               dv_item [DivSteps+1];
  logic [NumW-1:0]               dv_rp   [DivSteps+1];
  logic [NumW-1:0]               dv_rw   [DivSteps+1];
  logic [cpfg_pkg::Q_W-1:0]      dv_qp   [DivSteps+1];
  logic [cpfg_pkg::Q_W-1:0]      dv_qw   [DivSteps+1];

  assign dv_item[0] = ds_item_q;
  assign dv_rp[0]   = num_p_q;
  assign dv_rw[0]   = num_w_q;
  assign dv_qp[0]   = '0;
  assign dv_qw[0]   = '0;

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    cpfg_div_cell #(.NUM_W(NumW), .BIT(DivSteps - 1 - j)) u_cell (
      .clk_i   (clk_i),
      .en_i    (en),
      .item_i  (dv_item[j]),
      .rem_p_i (dv_rp[j]),
      .rem_w_i (dv_rw[j]),
      .q_p_i   (dv_qp[j]),
      .q_w_i   (dv_qw[j]),
      .item_o  (dv_item[j+1]),
      .rem_p_o (dv_rp[j+1]),
      .rem_w_o (dv_rw[j+1]),
      .q_p_o   (dv_qp[j+1]),
      .q_w_o   (dv_qw[j+1])
    );
  end

  // First finishing stage: saturate the slopes, round the angle and start the
  // three products that area and perimeter need.
  cpfg_pkg::item_t            fi;
  logic [cpfg_pkg::Q_W-1:0]   qp, qw;
  logic [cpfg_pkg::H_W:0]     theta_sum;
  logic [16:0]                theta_w;
  cpfg_pkg::res_t             p1_res_d, p1_res_q;
  logic [31:0]                p1_d2_q;
  logic signed [35:0]         p1_tc_q;
  logic [41:0]                p1_hd_q;
  logic [cpfg_pkg::H_W-1:0]   p1_h_q;

  always_comb begin
    fi        = dv_item[DivSteps];
    qp        = dv_qp[DivSteps];
    qw        = dv_qw[DivSteps];
    theta_sum = {1'b0, fi.h} + (cpfg_pkg::H_W+1)'(512);
    theta_w   = theta_sum[cpfg_pkg::H_W:10];
    p1_res_d       = '0;
    p1_res_d.theta = (theta_w > 17'(cpfg_pkg::THETA_MAX)) ? cpfg_pkg::THETA_MAX
                                                          : theta_w[15:0];
    p1_res_d.sat   = fi.ge || fi.le;
    p1_res_d.top   = fi.t;
    if (fi.ge) begin
      p1_res_d.pslope = 16'hFFFF;
      p1_res_d.wslope = 16'h8000;
    end else if (fi.le) begin
      p1_res_d.pslope = 16'hFFFF;
      p1_res_d.wslope = 16'h7FFF;
    end else begin
      p1_res_d.pslope = (fi.ovf_p || qp > 17'd65535) ? 16'hFFFF : qp[15:0];
      if (fi.c[cpfg_pkg::C_W-1]) begin
        p1_res_d.wslope = (fi.ovf_w || qw > 17'd32768) ? 16'h8000 : -qw[15:0];
      end else begin
        p1_res_d.wslope = (fi.ovf_w || qw > 17'd32767) ? 16'h7FFF : qw[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_res_q <= p1_res_d;
      p1_d2_q  <= fi.d * fi.d;
      p1_tc_q  <= $signed({1'b0, fi.t}) * $signed(fi.c);
      p1_hd_q  <= fi.h * fi.d;
      p1_h_q   <= fi.h;
    end
  end

  // Second stage: D^2 * h, and the rounded perimeter.
  cpfg_pkg::res_t      p2_res_d, p2_res_q;
  logic [41:0]         perim_sum;
  logic [57:0]         p2_m_q;
  logic signed [35:0]  p2_tc_q;

  always_comb begin
    perim_sum      = p1_hd_q + 42'(1 << 23);
    p2_res_d       = p1_res_q;
    p2_res_d.perim = perim_sum[41:24];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_res_q <= p2_res_d;
      p2_m_q   <= p1_d2_q * p1_h_q;
      p2_tc_q  <= p1_tc_q;
    end
  end

  // Third stage: the area difference D^2*h - T*c*2^24.
  cpfg_pkg::res_t      p3_res_q;
  logic signed [61:0]  p3_diff_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_res_q  <= p2_res_q;
      p3_diff_q <= $signed({4'b0000, p2_m_q}) - $signed({{2{p2_tc_q[35]}}, p2_tc_q, 24'd0});
    end
  end

  // Output stage: round and saturate the area, then hold the result.
  logic [60:0] area_sum, area_sh;
  logic [23:0] area_d;

  always_comb begin
    area_sum = p3_diff_q[60:0] + (61'(1) << (AreaSh - 1));
    area_sh  = area_sum >> AreaSh;
    if (p3_diff_q <= 0) begin
      area_d = '0;
    end else if (area_sh > 61'hFF_FFFF) begin
      area_d = 24'hFF_FFFF;
    end else begin
      area_d = area_sh[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      central_angle_o    <= p3_res_q.theta;
      flow_area_o        <= area_d;
      wetted_perimeter_o <= p3_res_q.perim;
      top_width_o        <= p3_res_q.top;
      perimeter_slope_o  <= p3_res_q.pslope;
      width_slope_o      <= p3_res_q.wslope;
      slope_saturated_o  <= p3_res_q.sat;
    end
  end

endmodule

// File: design/cpfg_sqrt_cell.sv
// One digit step of the pipelined integer square root.
// Depends on cpfg_pkg for widths and the beat structure.
module cpfg_sqrt_cell (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  cpfg_pkg::item_t               item_i,
  input  logic [cpfg_pkg::RAD_W-1:0]    rad_i,
  input  logic [cpfg_pkg::REM_W-1:0]    rem_i,
  input  logic [cpfg_pkg::T_W-1:0]      root_i,
  output cpfg_pkg::item_t               item_o,
  output logic [cpfg_pkg::RAD_W-1:0]    rad_o,
  output logic [cpfg_pkg::REM_W-1:0]    rem_o,
  output logic [cpfg_pkg::T_W-1:0]      root_o
);

  logic [cpfg_pkg::REM_W+1:0] cur;
  logic [cpfg_pkg::REM_W+1:0] trial;
  logic [cpfg_pkg::REM_W-1:0] rem_d;
  logic [cpfg_pkg::T_W-1:0]   root_d;

  // Bring down the next two radicand bits and try the digit one.
  always_comb begin
    cur   = {rem_i, rad_i[cpfg_pkg::RAD_W-1 -: 2]};
    trial = {1'b0, root_i, 2'b01};
    if (cur >= trial) begin
      rem_d  = cpfg_pkg::REM_W'(cur - trial);
      root_d = {root_i[cpfg_pkg::T_W-2:0], 1'b1};
    end else begin
      rem_d  = cur[cpfg_pkg::REM_W-1:0];
      root_d = {root_i[cpfg_pkg::T_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_o <= item_i;
      rad_o  <= {rad_i[cpfg_pkg::RAD_W-3:0], 2'b00};
      rem_o  <= rem_d;
      root_o <= root_d;
    end
  end

endmodule

// File: design/cpfg_cordic_cell.sv
// One vectoring stage of the CORDIC arctangent.
// Depends on cpfg_pkg for widths, the arctangent table and the beat structure.
module cpfg_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  cpfg_pkg::item_t                    item_i,
  input  logic signed [cpfg_pkg::X_W-1:0]    x_i,
  input  logic signed [cpfg_pkg::X_W-1:0]    y_i,
  input  logic signed [cpfg_pkg::Z_W-1:0]    z_i,
  output cpfg_pkg::item_t                    item_o,
  output logic signed [cpfg_pkg::X_W-1:0]    x_o,
  output logic signed [cpfg_pkg::X_W-1:0]    y_o,
  output logic signed [cpfg_pkg::Z_W-1:0]    z_o
);

  localparam logic [4:0] StageIdx = 5'(IDX);

  logic signed [cpfg_pkg::X_W-1:0] dx, dy, x_d, y_d;
  logic signed [cpfg_pkg::Z_W-1:0] ang, z_d;

  // Rotate towards the x axis; the shifts round towards minus infinity.
  always_comb begin
    dx  = y_i >>> IDX;
    dy  = x_i >>> IDX;
    ang = $signed(cpfg_pkg::atan_q24(StageIdx));
    if (y_i > 0) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ang;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_o <= item_i;
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
    end
  end

endmodule

// File: design/cpfg_div_cell.sv
// One restoring step of the two slope divisions, which share the divisor.
// Depends on cpfg_pkg for widths and the beat structure.
module cpfg_div_cell #(
  parameter int NUM_W = 26,
  parameter int BIT   = 16
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  cpfg_pkg::item_t               item_i,
  input  logic [NUM_W-1:0]              rem_p_i,
  input  logic [NUM_W-1:0]              rem_w_i,
  input  logic [cpfg_pkg::Q_W-1:0]      q_p_i,
  input  logic [cpfg_pkg::Q_W-1:0]      q_w_i,
  output cpfg_pkg::item_t               item_o,
  output logic [NUM_W-1:0]              rem_p_o,
  output logic [NUM_W-1:0]              rem_w_o,
  output logic [cpfg_pkg::Q_W-1:0]      q_p_o,
  output logic [cpfg_pkg::Q_W-1:0]      q_w_o
);

  localparam int CmpW = NUM_W + cpfg_pkg::Q_W;

  logic [CmpW-1:0]             dv;
  logic [NUM_W-1:0]            rem_p_d, rem_w_d;
  logic [cpfg_pkg::Q_W-1:0]    q_p_d, q_w_d, qbit;

  always_comb begin
    dv      = CmpW'(item_i.t) << BIT;
    qbit    = cpfg_pkg::Q_W'(1) << BIT;
    rem_p_d = rem_p_i;
    rem_w_d = rem_w_i;
    q_p_d   = q_p_i;
    q_w_d   = q_w_i;
    if (CmpW'(rem_p_i) >= dv) begin
      rem_p_d = rem_p_i - dv[NUM_W-1:0];
      q_p_d   = q_p_i | qbit;
    end
    if (CmpW'(rem_w_i) >= dv) begin
      rem_w_d = rem_w_i - dv[NUM_W-1:0];
      q_w_d   = q_w_i | qbit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_o  <= item_i;
      rem_p_o <= rem_p_d;
      rem_w_o <= rem_w_d;
      q_p_o   <= q_p_d;
      q_w_o   <= q_w_d;
    end
  end

endmodule

// File: design/cpfg_checker.sv
// Port-level checks for the circular pipe flow geometry unit, and the bind
// that attaches them to it. Depends only on the top level's ports.
module cpfg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] central_angle_o,
  input logic [23:0] flow_area_o,
  input logic [17:0] wetted_perimeter_o,
  input logic [16:0] top_width_o,
  input logic [15:0] perimeter_slope_o,
  input logic [15:0] width_slope_o,
  input logic        slope_saturated_o
);

  // The angle never exceeds a full turn.
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> central_angle_o <= 16'd51472)
    else $error("central angle above 2*pi");

  // A saturated beat always carries the largest perimeter slope.
  a_sat_pslope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && slope_saturated_o |-> perimeter_slope_o == 16'hFFFF)
    else $error("saturated beat without saturated perimeter slope");

  // An empty pipe gives no area, perimeter or width, and the upper width slope.
  a_empty_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && slope_saturated_o && central_angle_o == 16'd0 |->
      flow_area_o == 24'd0 && wetted_perimeter_o == 18'd0 &&
      top_width_o == 17'd0 && width_slope_o == 16'h7FFF)
    else $error("empty pipe beat with non-zero geometry");

  // The input side only stalls behind an untaken result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

  // A waiting result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(flow_area_o))
    else $error("result changed while stalled");

endmodule

bind circular_pipe_flow_geometry_unit cpfg_checker u_cpfg_checker (.*);

// File: tb/sv/tb_circular_pipe_flow_geometry_unit.sv
// Self-checking testbench for the circular pipe flow geometry unit.
// Depends on cpfg_pkg and circular_pipe_flow_geometry_unit; it predicts every
// result beat in software and compares it field by field with the block output.
module tb_circular_pipe_flow_geometry_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES = 16;
  localparam int FRACB  = 8;
  localparam int LATENCY = 41 + STAGES;

  typedef struct packed {
    logic [15:0] theta;
    logic [23:0] area;
    logic [17:0] perim;
    logic [16:0] top;
    logic [15:0] pslope;
    logic [15:0] wslope;
    logic        sat;
  } geom_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] flow_depth_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] central_angle_o;
  logic [23:0] flow_area_o;
  logic [17:0] wetted_perimeter_o;
  logic [16:0] top_width_o;
  logic [15:0] perimeter_slope_o;
  logic [15:0] width_slope_o;
  logic        slope_saturated_o;

  circular_pipe_flow_geometry_unit #(.CORDIC_STAGES(STAGES), .FRAC_BITS(FRACB)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o, .flow_depth_i,
    .out_valid_o, .out_ready_i, .central_angle_o, .flow_area_o, .wetted_perimeter_o,
    .top_width_o, .perimeter_slope_o, .width_slope_o, .slope_saturated_o
  );

  always #5 clk_i = ~clk_i;

  // Depths waiting to be driven and geometry results waiting to come out.
  logic [15:0] depth_queue[$];
  geom_t       geometry_queue[$];
  logic [15:0] diameter;      // the predictor's copy of the register
  int          mismatch_count = 0;
  int          accepted_depths = 0;
  bit          calm = 1'b0;   // set during the stretch with no idling
  bit          in_accepted = 1'b0;  // the input beat was taken at the last rising edge

  function automatic longint fshift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-(v + 1)) >>> s) - 1;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC giving atan2(yv, xv) in Q.24, clamped to 0..pi.
  function automatic longint half_angle(longint yv, longint xv);
    longint x, y, z, dx, dy, tmp;
    x = xv * 4096;
    y = yv * 4096;
    z = 0;
    if (x < 0) begin
      tmp = x;
      x = y;
      y = -tmp;
      z = cpfg_pkg::ANG_HALF_PI;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(cpfg_pkg::atan_q24(5'(i)));
      end else begin
        x -= dx; y += dy; z -= longint'(cpfg_pkg::atan_q24(5'(i)));
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(cpfg_pkg::ANG_PI)) z = cpfg_pkg::ANG_PI;
    return z;
  endfunction

  function automatic geom_t pipe_geometry(logic [15:0] depth_bits, logic [15:0] dia);
    geom_t  g;
    longint d, y, yc, t, c, h, diff, num, mag, q, ps, ws, th, ar, pe;
    d = dia;
    y = longint'($signed(depth_bits));
    yc = (y < 0) ? 0 : ((y > d) ? d : y);
    t = int_sqrt(4 * yc * (d - yc));
    c = d - 2 * yc;
    if (y >= d) begin
      h = cpfg_pkg::ANG_PI; g.sat = 1'b1; ps = 65535; ws = -32768;
    end else if (y <= 0) begin
      h = 0; g.sat = 1'b1; ps = 65535; ws = 32767;
    end else begin
      h = half_angle(t, c);
      g.sat = 1'b0;
      num = (2 * d) << FRACB;
      ps = (num + t / 2) / t;
      if (ps > 65535) ps = 65535;
      mag = (c < 0) ? -c : c;
      mag = (2 * mag) << FRACB;
      q = (mag + t / 2) / t;
      if (c < 0) ws = (q > 32768) ? -32768 : -q;
      else ws = (q > 32767) ? 32767 : q;
    end
    th = (h + 512) >> 10;
    if (th > 51472) th = 51472;
    diff = d * d * h - t * c * (longint'(1) << 24);
    if (diff <= 0) begin
      ar = 0;
    end else begin
      ar = (diff + (longint'(1) << (FRACB + 25))) >> (FRACB + 26);
      if (ar > 24'hFFFFFF) ar = 24'hFFFFFF;
    end
    pe = (h * d + (longint'(1) << 23)) >> 24;
    if (pe > 18'h3FFFF) pe = 18'h3FFFF;
    if (t > 17'h1FFFF) t = 17'h1FFFF;
    g.theta = th[15:0];
    g.area = ar[23:0];
    g.perim = pe[17:0];
    g.top = t[16:0];
    g.pslope = ps[15:0];
    g.wslope = ws[15:0];
    return g;
  endfunction

  // Driver: presents queued depths at the falling edge and holds each beat
  // until the rising edge at which it is accepted.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_accepted) begin
        // The previous beat, if any, has gone; choose the next action.
        if (depth_queue.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
          in_valid_i <= 1'b1;
          flow_depth_i <= depth_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          flow_depth_i <= 16'($urandom);
        end
      end
      out_ready_i <= calm || ($urandom_range(99) >= 34);
    end
  end

  // Monitor: predicts on every accepted depth and checks every result beat.
  always @(posedge clk_i) begin
    geom_t got, want;
    in_accepted <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        geometry_queue.push_back(pipe_geometry(flow_depth_i, diameter));
        accepted_depths++;
      end
      if (out_valid_o && out_ready_i) begin
        got = '{central_angle_o, flow_area_o, wetted_perimeter_o, top_width_o,
                perimeter_slope_o, width_slope_o, slope_saturated_o};
        if (geometry_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("ERROR: result beat with nothing expected");
        end else begin
          want = geometry_queue.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("ERROR: expected/actual angle %0d/%0d area %0d/%0d perim %0d/%0d",
                       want.theta, got.theta, want.area, got.area, want.perim, got.perim);
              $display("       top %0d/%0d dP %0d/%0d dT %0d/%0d sat %0b/%0b",
                       want.top, got.top, want.pslope, got.pslope,
                       $signed(want.wslope), $signed(got.wslope), want.sat, got.sat);
            end
          end
        end
      end
    end
  end

  // Writes the diameter register while the block is empty.
  task automatic set_diameter(logic [15:0] dia);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= dia;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    diameter = dia;
  endtask

  // Waits until every queued depth has been taken and every result checked.
  task automatic drain;
    while (depth_queue.size() > 0 || in_valid_i || geometry_queue.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic [15:0] random_depth(logic [15:0] dia);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 75 && dia > 1) return 16'($urandom_range(dia - 1, 1));
    if (pick < 82) return dia;
    if (pick < 88) return 16'(dia + $urandom_range(3));
    if (pick < 94) return 16'($urandom_range(1));
    return 16'($urandom);
  endfunction

  // Several diameters, the register extremes among them.
  logic [15:0] diameter_set[6] = '{16'd256, 16'd1, 16'd65535, 16'd0, 16'd2560, 16'd40000};

  initial begin
    diameter = 16'd256;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed depths under the reset diameter of 1.0: zero, negative, extremes,
    // half full, just inside both walls, full and over full.
    foreach (diameter_set[k]) begin
      if (k > 0) set_diameter(diameter_set[k]);
      if (k == 0) begin
        depth_queue = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'd1, 16'd64, 16'd128,
                        16'd192, 16'd255, 16'd256, 16'd257, 16'h5555, 16'hAAAA};
      end
      if (k == 5) calm = 1'b1;
      for (int n = 0; n < ((k == 0) ? 200 : 120); n++)
        depth_queue.push_back(random_depth(diameter));
      depth_queue.push_back(diameter);
      if (diameter > 1) depth_queue.push_back(16'(diameter - 1));
      drain();
      calm = 1'b0;
    end

    if (mismatch_count == 0 && geometry_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
